// ----- hdl/mvm_pkg.sv -----
package mvm_pkg;

  localparam int IDX_W     = 4;
  localparam int DATA_W    = 16;
  localparam int SUM_W     = 32;
  localparam int CNT_W     = 5;
  localparam int CFG_IDX_W = 1;
  localparam int ACC_W     = 2 * DATA_W + CNT_W + 1;

  localparam logic CMD_MAT = 1'b0;
  localparam logic CMD_VEC = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'b1;

  localparam logic [CNT_W-1:0] CNT_RESET = 5'd16;

  localparam logic signed [ACC_W-1:0] ACC_SUM_MAX =
    {{(ACC_W - SUM_W + 1){1'b0}}, {(SUM_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_SUM_MIN =
    {{(ACC_W - SUM_W + 1){1'b1}}, {(SUM_W - 1){1'b0}}};

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last_col;
    logic             last_row;
    logic             err;
    logic [IDX_W-1:0] row;
  } mac_ctl_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [IDX_W-1:0]        row_out;
    logic                    size_error;
    logic                    last_out;
  } result_t;

endpackage

// ----- hdl/mvm_if.sv -----
interface mvm_cfg_if import mvm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CNT_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface mvm_item_if import mvm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [IDX_W-1:0]         row_index;
  logic [IDX_W-1:0]         col_index;
  logic signed [DATA_W-1:0] value;
  logic                     last;

  modport source (output valid, cmd, row_index, col_index, value, last, input ready);
  modport sink (input valid, cmd, row_index, col_index, value, last, output ready);
endinterface

interface mvm_result_if import mvm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] sum;
  logic [IDX_W-1:0]        row_out;
  logic                    size_error;
  logic                    last_out;

  modport source (output valid, sum, row_out, size_error, last_out, input ready);
  modport sink (input valid, sum, row_out, size_error, last_out, output ready);
endinterface

// ----- hdl/mvm_ram.sv -----
module mvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/mvm_mac.sv -----
module mvm_mac import mvm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  mac_ctl_t                 ctl,
  input  logic signed [DATA_W-1:0] mat_data,
  input  logic signed [DATA_W-1:0] vec_data,
  output logic                     push,
  output result_t                  res
);

  logic signed [2*DATA_W-1:0] prod;
  logic signed [ACC_W-1:0]    acc;
  mac_ctl_t                   ctl_p;
  mac_ctl_t                   ctl_a;
  logic signed [SUM_W-1:0]    sat_sum;

  always_ff @(posedge clk) begin
    prod <= mat_data * vec_data;
    if (ctl_p.valid) begin
      if (ctl_p.first) begin
        acc <= ACC_W'(prod);
      end else begin
        acc <= acc + ACC_W'(prod);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_p <= '0;
      ctl_a <= '0;
    end else begin
      ctl_p <= ctl;
      ctl_a <= ctl_p;
    end
  end

  always_comb begin
    if (acc > ACC_SUM_MAX) begin
      sat_sum = ACC_SUM_MAX[SUM_W-1:0];
    end else if (acc < ACC_SUM_MIN) begin
      sat_sum = ACC_SUM_MIN[SUM_W-1:0];
    end else begin
      sat_sum = acc[SUM_W-1:0];
    end
  end

  assign push           = ctl_a.valid && ctl_a.last_col;
  assign res.sum        = ctl_a.err ? '0 : sat_sum;
  assign res.row_out    = ctl_a.err ? '0 : ctl_a.row;
  assign res.size_error = ctl_a.err;
  assign res.last_out   = ctl_a.last_row;

endmodule

// ----- hdl/mvm_res_fifo.sv -----
module mvm_res_fifo import mvm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t din,
  mvm_result_if.source result
);

  result_t    entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;
  result_t    head;

  assign pop  = result.valid && result.ready;
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign result.valid      = (count != 2'd0);
  assign result.sum        = head.sum;
  assign result.row_out    = head.row_out;
  assign result.size_error = head.size_error;
  assign result.last_out   = head.last_out;

endmodule

// ----- hdl/matrix_vector_multiply.sv -----
// Matrix-vector multiply, y = M * x, on signed Q8.8 elements with signed Q16.16 results.
// The cfg channel sets row_count and col_count; it is always ready. It must be written
// only while the block is idle; the block itself does not enforce this. Each item
// transaction writes one matrix element (cmd 0) or one vector element (cmd 1). A vector
// element with last set ends the vector. If its index plus one differs from col_count
// (clamped to 1 through MAX_COLS), one result with size_error set goes through ctl_q,
// the multiply-accumulate's ctl_p and ctl_a registers and the output queue. Otherwise
// the block reads one matrix and one vector element per cycle from its two memories
// through a single multiply-accumulate, but it waits at the start of a row while two
// results are waiting in the output queue or reserved for it. Each row gives one result
// transaction and the last row's result carries last_out.
// The item channel is not ready while a run is reading the memories, nor while two results
// are waiting in the queue or reserved for it.
// Up to two results wait in the output queue; when the receiver stalls, the sequencer
// pauses at the start of the next row and nothing is lost.
// Reset sets both counts to 16 and empties the pipeline and queue. The memories are not
// cleared, so every element used by a run must have been written first.
module matrix_vector_multiply import mvm_pkg::*; #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic clk,
  input  logic rst,
  mvm_cfg_if.sink      cfg,
  mvm_item_if.sink     item,
  mvm_result_if.source result
);

  localparam int MAT_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int MAW = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;
  localparam int VAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic [CNT_W-1:0] row_count;
  logic [CNT_W-1:0] col_count;
  logic [CNT_W-1:0] rows_eff;
  logic [CNT_W-1:0] cols_eff;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] row;
  logic [CNT_W-1:0] col;
  logic [1:0]       credit;
  logic [1:0]       credit_next;

  logic       accept;
  logic       start_run;
  logic       err_issue;
  logic       mismatch;
  logic       issue;
  logic       last_col;
  logic       last_row;
  logic       token_start;
  logic       pop;
  mac_ctl_t   ctl;
  mac_ctl_t   ctl_q;

  logic              mat_we;
  logic              vec_we;
  logic [MAW-1:0]    mat_waddr;
  logic [MAW-1:0]    mat_raddr;
  logic [VAW-1:0]    vec_waddr;
  logic [VAW-1:0]    vec_raddr;
  logic [DATA_W-1:0] mat_rdata;
  logic [DATA_W-1:0] vec_rdata;

  logic    push;
  result_t res;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= CNT_RESET;
      col_count <= CNT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.index == CFG_ROW_COUNT) begin
        row_count <= cfg.data;
      end
      if (cfg.index == CFG_COL_COUNT) begin
        col_count <= cfg.data;
      end
    end
  end

  always_comb begin
    if (row_count == '0) begin
      rows_eff = CNT_W'(1);
    end else if (int'(row_count) > MAX_ROWS) begin
      rows_eff = CNT_W'(MAX_ROWS);
    end else begin
      rows_eff = row_count;
    end
    if (col_count == '0) begin
      cols_eff = CNT_W'(1);
    end else if (int'(col_count) > MAX_COLS) begin
      cols_eff = CNT_W'(MAX_COLS);
    end else begin
      cols_eff = col_count;
    end
  end

  assign accept    = item.valid && item.ready;
  assign mismatch  = (int'(item.col_index) + 1) != int'(cols_eff);
  assign start_run = accept && (item.cmd == CMD_VEC) && item.last && !mismatch;
  assign err_issue = accept && (item.cmd == CMD_VEC) && item.last && mismatch;
  assign last_col  = (col == cols_eff - CNT_W'(1));
  assign last_row  = (row == rows_eff - CNT_W'(1));
  assign pop       = result.valid && result.ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start_run) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (issue && last_col && last_row) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    item.ready = 1'b0;
    issue      = 1'b0;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        item.ready = (credit != 2'd2);
        if (err_issue) begin
          ctl.valid    = 1'b1;
          ctl.first    = 1'b1;
          ctl.last_col = 1'b1;
          ctl.last_row = 1'b1;
          ctl.err      = 1'b1;
        end
      end
      S_RUN: begin
        issue        = (col != '0) || (credit != 2'd2);
        ctl.valid    = issue;
        ctl.first    = (col == '0);
        ctl.last_col = last_col;
        ctl.last_row = last_row;
        ctl.row      = row[IDX_W-1:0];
      end
      default: begin
        item.ready = 1'b0;
      end
    endcase
  end

  assign token_start = err_issue || (issue && (col == '0));
  assign credit_next = credit + {1'b0, token_start} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      row    <= '0;
      col    <= '0;
      credit <= 2'd0;
      ctl_q  <= '0;
    end else begin
      state  <= state_next;
      credit <= credit_next;
      ctl_q  <= ctl;
      if (start_run) begin
        row <= '0;
        col <= '0;
      end else if (issue) begin
        if (last_col) begin
          col <= '0;
          row <= row + CNT_W'(1);
        end else begin
          col <= col + CNT_W'(1);
        end
      end
    end
  end

  assign mat_we    = accept && (item.cmd == CMD_MAT) && (int'(item.row_index) < MAX_ROWS)
                     && (int'(item.col_index) < MAX_COLS);
  assign vec_we    = accept && (item.cmd == CMD_VEC) && (int'(item.col_index) < MAX_COLS);
  assign mat_waddr = MAW'(int'(item.row_index) * MAX_COLS + int'(item.col_index));
  assign vec_waddr = VAW'(item.col_index);
  assign mat_raddr = MAW'(int'(row) * MAX_COLS + int'(col));
  assign vec_raddr = VAW'(col);

  mvm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAT_DEPTH),
    .AW    (MAW)
  ) u_mat_ram (
    .clk   (clk),
    .we    (mat_we),
    .waddr (mat_waddr),
    .wdata (item.value),
    .raddr (mat_raddr),
    .rdata (mat_rdata)
  );

  mvm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_COLS),
    .AW    (VAW)
  ) u_vec_ram (
    .clk   (clk),
    .we    (vec_we),
    .waddr (vec_waddr),
    .wdata (item.value),
    .raddr (vec_raddr),
    .rdata (vec_rdata)
  );

  mvm_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl_q),
    .mat_data (signed'(mat_rdata)),
    .vec_data (signed'(vec_rdata)),
    .push     (push),
    .res      (res)
  );

  mvm_res_fifo u_res_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .din    (res),
    .result (result)
  );

  assert property (@(posedge clk) disable iff (rst) item.ready |-> state == S_IDLE)
    else $error("item channel ready while a run is reading the memories");

  assert property (@(posedge clk) disable iff (rst) push |-> credit != 2'd0)
    else $error("result pushed without a reserved queue slot");

  assert property (@(posedge clk) disable iff (rst) start_run |=> state == S_RUN && col == '0)
    else $error("run did not start after the final vector element");

  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.size_error |-> result.last_out && result.sum == '0)
    else $error("size error result is not a single marked zero result");

endmodule
